### rtl/assert_macros.svh
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/trz_pkg.sv
// Shared widths, codes and interface types of the triangle rasterizer.
package trz_pkg;

    localparam int XYW   = 16;
    localparam int DEPW  = 16;
    localparam int COLW  = 24;
    localparam int CHW   = 8;
    localparam int NCH   = 3;
    localparam int PW    = 12;
    localparam int EW    = 35;
    localparam int AREAW = 33;
    localparam int NZW   = 51;
    localparam int NCW   = 42;
    localparam int QZW   = 16;
    localparam int CNTW  = 17;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFGW  = 9;
    localparam int CFGIW = 1;
    localparam logic [CFGIW-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFGIW-1:0] CFG_SCREEN_HEIGHT = 1'b1;
    localparam logic [CFGW-1:0]  SCREEN_RESET      = 9'd256;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [DEPW-1:0] DEPTH_FAR = 16'h7FFF;
    localparam logic [DEPW-1:0] DEPTH_BIAS = 16'h8000;
    localparam logic [CNTW-1:0] COUNT_SAT = '1;

    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 80;

    typedef struct packed {
        logic                      start;
        logic [AREAW-1:0]          area;
        logic [NZW-1:0]            num_z;
        logic [NCH-1:0][NCW-1:0]   num_c;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QZW-1:0]   q_z;
        logic [COLW-1:0]  rgb;
    } t_div_rsp;

endpackage

### rtl/trz_div.sv
// Restoring divider for the biased depth and the three colour channels.
module trz_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  trz_pkg::t_div_req i_req,
    output trz_pkg::t_div_rsp o_rsp
);
    import trz_pkg::*;

    localparam int DVSW = AREAW + QZW - 1;
    localparam int SW   = $clog2(QZW);

    logic                          r_busy;
    logic                          r_done;
    logic [SW-1:0]                 r_step;
    logic [DVSW-1:0]               r_dvs;
    logic [NZW-1:0]                r_rem_z;
    logic [QZW-1:0]                r_q_z;
    logic [NCH-1:0][NCW-1:0]       r_rem_c;
    logic [NCH-1:0][CHW-1:0]       r_q_c;
    logic [NZW:0]                  n_try_z;
    logic [NCH-1:0][DVSW:0]        n_try_c;

    always_comb begin
        n_try_z = {1'b0, r_rem_z} - (NZW+1)'(r_dvs);
        for (int i = 0; i < NCH; i++) begin
            n_try_c[i] = (DVSW+1)'(r_rem_c[i]) - {1'b0, r_dvs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_step  <= SW'(QZW - 1);
                r_dvs   <= DVSW'(i_req.area) << (QZW - 1);
                r_rem_z <= i_req.num_z;
                r_rem_c <= i_req.num_c;
            end else if (r_busy) begin
                if (!n_try_z[NZW]) begin
                    r_rem_z <= n_try_z[NZW-1:0];
                end
                r_q_z <= {r_q_z[QZW-2:0], !n_try_z[NZW]};
                if (r_step < SW'(CHW)) begin
                    for (int i = 0; i < NCH; i++) begin
                        if (!n_try_c[i][DVSW]) begin
                            r_rem_c[i] <= NCW'(n_try_c[i]);
                        end
                        r_q_c[i] <= {r_q_c[i][CHW-2:0], !n_try_c[i][DVSW]};
                    end
                end
                r_dvs  <= r_dvs >> 1;
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, q_z: r_q_z, rgb: r_q_c};

endmodule

### rtl/triangle_rasterizer_zbuffer.sv
// Top level of the edge-function triangle rasterizer with depth store.
//
// After reset the block sweeps its pixel store once, one entry a cycle, to
// far depth and black; during the sweep s_axis_tready stays low, while
// configuration writes are taken at any time. A read transaction passes
// through S_READ and S_DONE to its result. A draw sets up in S_AREA and
// S_BOX, then walks the clamped bounding box one pixel at a time; a covered
// pixel waits on the 16-step divider that divides depth and colour by the
// triangle area. The result waits in an output register and one draw
// runs at a time. tuser in: op; tuser out: degenerate.
`include "assert_macros.svh"

module triangle_rasterizer_zbuffer #(
    parameter int MAX_WIDTH  = trz_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = trz_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // vertex0_xy, vertex0_depth, vertex1_xy, vertex1_depth, vertex2_xy,
    // vertex2_depth, color0, color1, color2, read_x, read_y
    input  logic [trz_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pixels_covered, pixels_written, read_color, read_depth, zero pad
    output logic [trz_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // degenerate
    output logic                               m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [trz_pkg::CFGIW-1:0]          i_cfg_index,
    input  logic [trz_pkg::CFGW-1:0]           i_cfg_data
);
    import trz_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDRW = $clog2(DEPTH);
    localparam int MEMW  = DEPW + COLW;
    localparam int LW    = PW + 1;
    localparam int PZW   = DEPW + AREAW;
    localparam int PCW   = CHW + AREAW;
    localparam int OPAD  = OUT_TDATA_W - 2 * CNTW - COLW - DEPW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_AREA, S_BOX, S_EDGE, S_TEST, S_SUM, S_DIV,
        S_NEXT, S_DONE
    } t_state;

    t_state                        r_state;
    logic [CFGW-1:0]               r_scr_w;
    logic [CFGW-1:0]               r_scr_h;
    logic [ADDRW-1:0]              r_clr_addr;
    logic [MEMW-1:0]               r_mem [DEPTH];
    logic [MEMW-1:0]               r_rd_data;
    logic [2:0][XYW-1:0]           r_vx;
    logic [2:0][XYW-1:0]           r_vy;
    logic [2:0][DEPW-1:0]          r_vz;
    logic [2:0][COLW-1:0]          r_col;
    logic                          r_oor;
    logic signed [EW-1:0]          r_area;
    logic [AREAW-1:0]              r_area_abs;
    logic [PW-1:0]                 r_minx, r_maxx, r_miny, r_maxy, r_x, r_y;
    logic signed [EW-1:0]          r_e [3];
    logic [2:0][PZW-1:0]           r_pz;
    logic [2:0][NCH-1:0][PCW-1:0]  r_pc;
    logic [CNTW-1:0]               r_cov, r_wr;
    logic                          r_deg;
    logic [COLW-1:0]               r_rcol;
    logic [DEPW-1:0]               r_rdep;
    logic                          r_m_valid;
    logic [OUT_TDATA_W-1:0]        r_m_data;
    logic                          r_m_user;

    logic                          s_fire;
    logic [PW-1:0]                 n_wm1, n_hm1;
    logic signed [EW-1:0]          n_area;
    logic [ADDRW-1:0]              pix_addr, rd_addr, wr_addr;
    logic                          rd_en, wr_en;
    logic [MEMW-1:0]               wr_data;
    logic                          in_oor;
    logic [DEPW-1:0]               n_z;
    logic                          nearer;
    t_div_req                      div_req;
    t_div_rsp                      div_rsp;

    function automatic logic signed [EW-1:0] edge_fn(
        input logic [XYW-1:0] ax, input logic [XYW-1:0] ay,
        input logic [XYW-1:0] bx, input logic [XYW-1:0] by,
        input logic [XYW-1:0] cx, input logic [XYW-1:0] cy);
        logic signed [XYW:0]     dcx, dby, dcy, dbx;
        logic signed [2*XYW+1:0] p0, p1;
        dcx = $signed({1'b0, cx}) - $signed({1'b0, ax});
        dby = $signed({1'b0, by}) - $signed({1'b0, ay});
        dcy = $signed({1'b0, cy}) - $signed({1'b0, ay});
        dbx = $signed({1'b0, bx}) - $signed({1'b0, ax});
        p0  = dcx * dby;
        p1  = dcy * dbx;
        return EW'(p0) - EW'(p1);
    endfunction

    function automatic logic [PW-1:0] min3(input logic [PW-1:0] a,
        input logic [PW-1:0] b, input logic [PW-1:0] c);
        logic [PW-1:0] m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    function automatic logic [PW-1:0] max3(input logic [PW-1:0] a,
        input logic [PW-1:0] b, input logic [PW-1:0] c);
        logic [PW-1:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    always_comb begin
        n_wm1 = (r_scr_w == '0) ? '0 :
                (LW'(r_scr_w) > LW'(MAX_WIDTH)) ? PW'(MAX_WIDTH - 1) :
                PW'(r_scr_w - 1'b1);
        n_hm1 = (r_scr_h == '0) ? '0 :
                (LW'(r_scr_h) > LW'(MAX_HEIGHT)) ? PW'(MAX_HEIGHT - 1) :
                PW'(r_scr_h - 1'b1);
        n_area = edge_fn(r_vx[0], r_vy[0], r_vx[1], r_vy[1], r_vx[2], r_vy[2]);
        in_oor = (LW'(s_axis_tdata[223:216]) >= LW'(MAX_WIDTH)) ||
                 (LW'(s_axis_tdata[231:224]) >= LW'(MAX_HEIGHT));
        pix_addr = ADDRW'(ADDRW'(r_y) * ADDRW'(MAX_WIDTH)) + ADDRW'(r_x);

        rd_en   = (s_fire && s_axis_tuser == OP_READ) || (r_state == S_EDGE);
        rd_addr = pix_addr;
        if (r_state == S_IDLE) begin
            rd_addr = in_oor ? '0 :
                ADDRW'(ADDRW'(s_axis_tdata[231:224]) * ADDRW'(MAX_WIDTH)) +
                ADDRW'(s_axis_tdata[223:216]);
        end

        n_z    = div_rsp.q_z ^ DEPTH_BIAS;
        nearer = $signed(n_z) < $signed(r_rd_data[MEMW-1:COLW]);

        wr_en   = 1'b0;
        wr_addr = pix_addr;
        wr_data = {n_z, div_rsp.rgb};
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = {DEPTH_FAR, COLW'(0)};
        end else if (r_state == S_DIV && div_rsp.done && nearer) begin
            wr_en = 1'b1;
        end

        div_req.start = (r_state == S_SUM);
        div_req.area  = r_area_abs;
        div_req.num_z = NZW'(r_pz[0]) + NZW'(r_pz[1]) + NZW'(r_pz[2]);
        for (int c = 0; c < NCH; c++) begin
            div_req.num_c[c] = NCW'(r_pc[0][c]) + NCW'(r_pc[1][c]) +
                               NCW'(r_pc[2][c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= SCREEN_RESET;
            r_scr_h <= SCREEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    trz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (m_axis_tready && r_state != S_DONE) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDRW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        r_vx[0]  <= s_axis_tdata[15:0];
                        r_vy[0]  <= s_axis_tdata[31:16];
                        r_vz[0]  <= s_axis_tdata[47:32];
                        r_vx[1]  <= s_axis_tdata[63:48];
                        r_vy[1]  <= s_axis_tdata[79:64];
                        r_vz[1]  <= s_axis_tdata[95:80];
                        r_vx[2]  <= s_axis_tdata[111:96];
                        r_vy[2]  <= s_axis_tdata[127:112];
                        r_vz[2]  <= s_axis_tdata[143:128];
                        r_col[0] <= s_axis_tdata[167:144];
                        r_col[1] <= s_axis_tdata[191:168];
                        r_col[2] <= s_axis_tdata[215:192];
                        r_oor    <= in_oor;
                        r_cov    <= '0;
                        r_wr     <= '0;
                        r_deg    <= 1'b0;
                        r_rcol   <= '0;
                        r_rdep   <= '0;
                        r_state  <= (s_axis_tuser == OP_READ) ? S_READ : S_AREA;
                    end
                end
                S_READ: begin
                    r_rcol  <= r_oor ? '0 : r_rd_data[COLW-1:0];
                    r_rdep  <= r_oor ? DEPTH_FAR : r_rd_data[MEMW-1:COLW];
                    r_state <= S_DONE;
                end
                S_AREA: begin
                    r_area <= n_area;
                    r_minx <= min3(r_vx[0][XYW-1:4], r_vx[1][XYW-1:4], r_vx[2][XYW-1:4]);
                    r_miny <= min3(r_vy[0][XYW-1:4], r_vy[1][XYW-1:4], r_vy[2][XYW-1:4]);
                    r_maxx <= (max3(r_vx[0][XYW-1:4], r_vx[1][XYW-1:4],
                               r_vx[2][XYW-1:4]) > n_wm1) ? n_wm1 :
                              max3(r_vx[0][XYW-1:4], r_vx[1][XYW-1:4], r_vx[2][XYW-1:4]);
                    r_maxy <= (max3(r_vy[0][XYW-1:4], r_vy[1][XYW-1:4],
                               r_vy[2][XYW-1:4]) > n_hm1) ? n_hm1 :
                              max3(r_vy[0][XYW-1:4], r_vy[1][XYW-1:4], r_vy[2][XYW-1:4]);
                    r_state <= S_BOX;
                end
                S_BOX: begin
                    r_area_abs <= r_area[EW-1] ? AREAW'(-r_area) : AREAW'(r_area);
                    if (r_area[EW-1]) begin
                        r_vx[1]  <= r_vx[2];
                        r_vx[2]  <= r_vx[1];
                        r_vy[1]  <= r_vy[2];
                        r_vy[2]  <= r_vy[1];
                        r_vz[1]  <= r_vz[2];
                        r_vz[2]  <= r_vz[1];
                        r_col[1] <= r_col[2];
                        r_col[2] <= r_col[1];
                    end
                    r_x <= r_minx;
                    r_y <= r_miny;
                    if (r_area == '0) begin
                        r_deg   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_minx > r_maxx || r_miny > r_maxy) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    r_e[0]  <= edge_fn(r_vx[1], r_vy[1], r_vx[2], r_vy[2],
                                       {r_x, 4'h8}, {r_y, 4'h8});
                    r_e[1]  <= edge_fn(r_vx[2], r_vy[2], r_vx[0], r_vy[0],
                                       {r_x, 4'h8}, {r_y, 4'h8});
                    r_e[2]  <= edge_fn(r_vx[0], r_vy[0], r_vx[1], r_vy[1],
                                       {r_x, 4'h8}, {r_y, 4'h8});
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    if (r_e[0][EW-1] || r_e[1][EW-1] || r_e[2][EW-1]) begin
                        r_state <= S_NEXT;
                    end else begin
                        if (r_cov != COUNT_SAT) begin
                            r_cov <= r_cov + 1'b1;
                        end
                        for (int i = 0; i < 3; i++) begin
                            r_pz[i] <= (r_vz[i] ^ DEPTH_BIAS) * r_e[i][AREAW-1:0];
                            for (int c = 0; c < NCH; c++) begin
                                r_pc[i][c] <= r_col[i][c*CHW +: CHW] * r_e[i][AREAW-1:0];
                            end
                        end
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (nearer && r_wr != COUNT_SAT) begin
                            r_wr <= r_wr + 1'b1;
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_state <= S_EDGE;
                    if (r_x == r_maxx) begin
                        r_x <= r_minx;
                        r_y <= r_y + 1'b1;
                        if (r_y == r_maxy) begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {OPAD'(0), r_rdep, r_rcol, r_wr, r_cov};
                        r_m_user  <= r_deg;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_clear_blocks_input, i_clk, i_rst_n, r_state == S_CLEAR,
        !s_axis_tready, "input taken during store clear")
    `ASSERT_IMPL(a_written_le_covered, i_clk, i_rst_n, r_m_valid,
        r_m_data[2*CNTW-1:CNTW] <= r_m_data[CNTW-1:0],
        "written count above covered count")
    `ASSERT_IMPL(a_write_source, i_clk, i_rst_n, wr_en,
        r_state == S_CLEAR || div_rsp.done, "store write outside clear or pixel update")
    `ASSERT_IMPL(a_div_done_state, i_clk, i_rst_n, div_rsp.done,
        r_state == S_DIV, "divider finished outside its wait state")

endmodule
